/* rtl/core/ssp_pkg.sv */
package ssp_pkg;

    localparam int INDEX_BITS     = 32;
    localparam int SQRT_STAGES    = (INDEX_BITS + 3) / 4;
    localparam int ROOT_BITS      = 2 * SQRT_STAGES;
    localparam int RAD_BITS       = 2 * ROOT_BITS;
    localparam int REM_BITS       = ROOT_BITS + 2;
    localparam int COORD_BITS     = 17;
    localparam int IN_TDATA_BITS  = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int LATENCY        = SQRT_STAGES + 3;

    typedef logic [ROOT_BITS-1:0] root_t;
    typedef logic [REM_BITS-1:0]  rem_t;
    typedef logic [RAD_BITS-1:0]  rad_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        root_t root;
        rem_t  rem;
    } sqrt_res_t;

endpackage

/* rtl/core/square_spiral_index_to_point.sv */
// A request passes through the root pipeline, then stages A, B and C, to the result.
// Throughput: one request per cycle while the output is not stalled; the root pipeline takes two root bits per stage.
// Stalls on m_axis_tready hold every stage; empty stages still fill.
// Reset: rst_n asynchronous, active low, clears all stage valid bits.
module square_spiral_index_to_point (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,   // index
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata    // x, y
);

    localparam int P_BITS = ssp_pkg::REM_BITS;
    localparam int M_BITS = ssp_pkg::ROOT_BITS + 3;
    localparam int S_BITS = ssp_pkg::ROOT_BITS + 4;

    typedef logic signed [S_BITS-1:0] wide_t;
    typedef logic [P_BITS-1:0]        off_t;

    typedef enum logic [1:0] {
        SIDE_RIGHT,
        SIDE_BOTTOM,
        SIDE_LEFT,
        SIDE_TOP
    } side_t;

    logic               sq_valid;
    logic               sq_ready;
    ssp_pkg::sqrt_res_t sq_res;

    ssp_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .rad       (ssp_pkg::RAD_BITS'(s_axis_tdata[ssp_pkg::INDEX_BITS-1:0])),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .res       (sq_res)
    );

    // stage A: ring and offset
    logic                  a_valid_reg;
    logic                  a_zero_reg,  a_zero_next;
    ssp_pkg::root_t        a_c_reg,     a_c_next;
    off_t                  a_p_reg,     a_p_next;
    // stage B: side and constants
    logic                  b_valid_reg;
    logic                  b_zero_reg;
    side_t                 b_side_reg,  b_side_next;
    wide_t                 b_c_reg,     b_c_next;
    wide_t                 b_p_reg,     b_p_next;
    wide_t                 b_c1_reg,    b_c1_next;
    wide_t                 b_c3_reg,    b_c3_next;
    wide_t                 b_c5_reg,    b_c5_next;
    wide_t                 b_c7_reg,    b_c7_next;
    // stage C: output register
    logic                  c_valid_reg;
    ssp_pkg::coord_t       c_x_reg,     c_x_next;
    ssp_pkg::coord_t       c_y_reg,     c_y_next;

    logic adv_a, adv_b, adv_c;

    assign adv_c    = !c_valid_reg || m_axis_tready;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign sq_ready = adv_a;

    always_comb
    begin
        logic [ssp_pkg::ROOT_BITS:0] r_inc;
        logic [P_BITS:0]             p_sum;
        r_inc = (ssp_pkg::ROOT_BITS + 1)'(sq_res.root) + (ssp_pkg::ROOT_BITS + 1)'(1);
        p_sum = (P_BITS + 1)'(sq_res.rem) + (P_BITS + 1)'({sq_res.root, 1'b0})
              - (P_BITS + 1)'(1);
        a_c_next    = r_inc[ssp_pkg::ROOT_BITS:1];
        a_p_next    = sq_res.root[0] ? sq_res.rem : P_BITS'(p_sum);
        a_zero_next = (sq_res.root == '0);
    end

    always_comb
    begin
        logic [M_BITS-1:0] c2;
        logic [M_BITS-1:0] c4;
        logic [M_BITS-1:0] c6;
        logic [M_BITS-1:0] pm;
        c2 = M_BITS'(a_c_reg) << 1;
        c4 = M_BITS'(a_c_reg) << 2;
        c6 = c2 + c4;
        pm = M_BITS'(a_p_reg);
        if (pm >= c6)
            b_side_next = SIDE_TOP;
        else if (pm >= c4)
            b_side_next = SIDE_LEFT;
        else if (pm >= c2)
            b_side_next = SIDE_BOTTOM;
        else
            b_side_next = SIDE_RIGHT;
        b_c_next  = wide_t'(a_c_reg);
        b_p_next  = wide_t'(a_p_reg);
        b_c1_next = wide_t'(a_c_reg) - wide_t'(1);
        b_c3_next = wide_t'(c2) + wide_t'(a_c_reg) - wide_t'(1);
        b_c5_next = wide_t'(c4) + wide_t'(a_c_reg) - wide_t'(1);
        b_c7_next = wide_t'(c6) + wide_t'(a_c_reg) - wide_t'(1);
    end

    always_comb
    begin
        wide_t xw;
        wide_t yw;
        unique case (b_side_reg)
            SIDE_RIGHT:
            begin
                xw = b_c_reg;
                yw = b_c1_reg - b_p_reg;
            end
            SIDE_BOTTOM:
            begin
                xw = b_c3_reg - b_p_reg;
                yw = -b_c_reg;
            end
            SIDE_LEFT:
            begin
                xw = -b_c_reg;
                yw = b_p_reg - b_c5_reg;
            end
            SIDE_TOP:
            begin
                xw = b_p_reg - b_c7_reg;
                yw = b_c_reg;
            end
            default:
            begin
                xw = '0;
                yw = '0;
            end
        endcase
        if (b_zero_reg)
        begin
            xw = '0;
            yw = '0;
        end
        c_x_next = ssp_pkg::COORD_BITS'(xw);
        c_y_next = ssp_pkg::COORD_BITS'(yw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_valid_reg <= sq_valid;
            if (adv_b)
                b_valid_reg <= a_valid_reg;
            if (adv_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_zero_reg <= a_zero_next;
            a_c_reg    <= a_c_next;
            a_p_reg    <= a_p_next;
        end
        if (adv_b)
        begin
            b_zero_reg <= a_zero_reg;
            b_side_reg <= b_side_next;
            b_c_reg    <= b_c_next;
            b_p_reg    <= b_p_next;
            b_c1_reg   <= b_c1_next;
            b_c3_reg   <= b_c3_next;
            b_c5_reg   <= b_c5_next;
            b_c7_reg   <= b_c7_next;
        end
        if (adv_c)
        begin
            c_x_reg <= c_x_next;
            c_y_reg <= c_y_next;
        end
    end

    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tdata  = ssp_pkg::OUT_TDATA_BITS'({c_y_reg, c_x_reg});

endmodule

/* rtl/core/ssp_isqrt.sv */
module ssp_isqrt (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssp_pkg::rad_t     rad,
    output logic              out_valid,
    input  logic              out_ready,
    output ssp_pkg::sqrt_res_t res
);

    localparam int N = ssp_pkg::SQRT_STAGES;
    localparam int W = ssp_pkg::RAD_BITS;

    logic                valid_reg [N];
    ssp_pkg::rad_t       rad_reg   [N-1];
    ssp_pkg::sqrt_res_t  res_reg   [N];
    ssp_pkg::sqrt_res_t  res_next  [N];
    logic                adv       [N];

    // one digit of the restoring square root
    function automatic ssp_pkg::sqrt_res_t sqrt_step(input ssp_pkg::sqrt_res_t cur,
                                                     input logic [1:0] pair);
        logic [ssp_pkg::REM_BITS+1:0] acc;
        logic [ssp_pkg::REM_BITS+1:0] sub;
        ssp_pkg::sqrt_res_t           nxt;
        acc = {cur.rem, pair};
        sub = (ssp_pkg::REM_BITS + 2)'({cur.root, 2'b01});
        if (acc >= sub)
        begin
            nxt.rem  = ssp_pkg::REM_BITS'(acc - sub);
            nxt.root = {cur.root[ssp_pkg::ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            nxt.rem  = ssp_pkg::REM_BITS'(acc);
            nxt.root = {cur.root[ssp_pkg::ROOT_BITS-2:0], 1'b0};
        end
        return nxt;
    endfunction

    always_comb
    begin
        adv[N-1] = !valid_reg[N-1] || out_ready;
        for (int s = N - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    always_comb
    begin
        ssp_pkg::sqrt_res_t cur;
        cur.root = '0;
        cur.rem  = '0;
        cur = sqrt_step(cur, rad[W-1 -: 2]);
        res_next[0] = sqrt_step(cur, rad[W-3 -: 2]);
        for (int s = 1; s < N; s++)
        begin
            cur = sqrt_step(res_reg[s-1], rad_reg[s-1][W-1-4*s -: 2]);
            res_next[s] = sqrt_step(cur, rad_reg[s-1][W-3-4*s -: 2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < N; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < N; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rad_reg[0] <= rad;
        end
        for (int s = 1; s < N - 1; s++)
        begin
            if (adv[s])
            begin
                rad_reg[s] <= rad_reg[s-1];
            end
        end
        for (int s = 0; s < N; s++)
        begin
            if (adv[s])
            begin
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[N-1];
    assign res       = res_reg[N-1];

endmodule

/* rtl/core/ssp_checker.sv */
module ssp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [ssp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [ssp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int LAT      = ssp_pkg::LATENCY;
    localparam int RUN_BITS = $clog2(LAT + 1);

    logic [LAT-1:0]      zero_hist_reg;
    logic [RUN_BITS-1:0] ready_run_reg;
    logic                acc_zero;

    assign acc_zero = s_axis_tvalid && s_axis_tready
                   && (s_axis_tdata[ssp_pkg::INDEX_BITS-1:0] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_hist_reg <= '0;
            ready_run_reg <= '0;
        end
        else
        begin
            zero_hist_reg <= {zero_hist_reg[LAT-2:0], acc_zero};
            if (!m_axis_tready)
                ready_run_reg <= '0;
            else if (ready_run_reg != RUN_BITS'(LAT))
                ready_run_reg <= ready_run_reg + RUN_BITS'(1);
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // centre request with no stall reaches the output after the pipeline depth
    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        zero_hist_reg[LAT-1] && (ready_run_reg >= RUN_BITS'(LAT - 1))
        |-> m_axis_tvalid && (m_axis_tdata[2*ssp_pkg::COORD_BITS-1:0] == '0))
        else $error("centre index did not give origin on time");

endmodule

bind square_spiral_index_to_point ssp_checker u_ssp_checker (.*);

/* verif/tb_top.sv */
module tb_top;

    typedef enum logic [1:0] {SIDE_RIGHT, SIDE_BOTTOM, SIDE_LEFT, SIDE_TOP} ring_side_t;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

    typedef struct packed {
        ssp_pkg::coord_t y;
        ssp_pkg::coord_t x;
    } cell_t;

    typedef struct {
        logic [ssp_pkg::INDEX_BITS-1:0] index;
        cell_t                          pt;
    } pending_cell_t;

    class cell_scoreboard;
        pending_cell_t expected_cells[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 16; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n)
                    root = trial;
            end
            return root;
        endfunction

        function cell_t spiral_cell(logic [ssp_pkg::INDEX_BITS-1:0] index);
            longint     idx_l;
            longint     ring;
            longint     span;
            longint     offs;
            longint     px;
            longint     py;
            ring_side_t side;
            cell_t      pt;
            idx_l = 0;
            idx_l[ssp_pkg::INDEX_BITS-1:0] = index;
            if (idx_l == 0)
                return '0;
            ring = longint'((floor_sqrt(idx_l) + 1) / 2);
            span = 2 * ring - 1;
            offs = idx_l - span * span;
            side = ring_side_t'(offs / (2 * ring));
            case (side)
                SIDE_RIGHT:
                begin
                    px = ring;
                    py = ring - 1 - offs;
                end
                SIDE_BOTTOM:
                begin
                    px = 3 * ring - 1 - offs;
                    py = -ring;
                end
                SIDE_LEFT:
                begin
                    px = -ring;
                    py = offs - 5 * ring + 1;
                end
                default:
                begin
                    px = offs - 7 * ring + 1;
                    py = ring;
                end
            endcase
            pt.x = px[ssp_pkg::COORD_BITS-1:0];
            pt.y = py[ssp_pkg::COORD_BITS-1:0];
            return pt;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void note_request(logic [ssp_pkg::INDEX_BITS-1:0] index);
            pending_cell_t entry;
            entry.index = index;
            entry.pt    = spiral_cell(index);
            expected_cells.push_back(entry);
        endfunction

        function void check_cell(logic [ssp_pkg::OUT_TDATA_BITS-1:0] data);
            pending_cell_t   want;
            ssp_pkg::coord_t got_x;
            ssp_pkg::coord_t got_y;
            got_x = data[ssp_pkg::COORD_BITS-1:0];
            got_y = data[2*ssp_pkg::COORD_BITS-1:ssp_pkg::COORD_BITS];
            if (expected_cells.size() == 0)
            begin
                flag($sformatf("unexpected result (%0d,%0d)", $signed(got_x), $signed(got_y)));
                return;
            end
            want = expected_cells.pop_front();
            if (got_x !== want.pt.x || got_y !== want.pt.y)
                flag($sformatf("index %0d: expected (%0d,%0d) got (%0d,%0d)", want.index,
                               $signed(want.pt.x), $signed(want.pt.y),
                               $signed(got_x), $signed(got_y)));
        endfunction

        function int outstanding();
            return expected_cells.size();
        endfunction

        function void close_out();
            if (expected_cells.size() != 0)
                flag($sformatf("%0d results never arrived", expected_cells.size()));
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b1;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ssp_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata = '0;   // index
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ssp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;        // x, y

    cell_scoreboard sb;

    square_spiral_index_to_point dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("[square_spiral_index_to_point] ERROR");
        $finish;
    end

    task automatic send_index(input logic [ssp_pkg::INDEX_BITS-1:0] index);
        s_axis_tdata  <= index;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(index);
    endtask

    // mix of full-range values, small rings, ring corners, perfect squares and values near the top of the range
    function automatic logic [ssp_pkg::INDEX_BITS-1:0] pick_index();
        longint ring;
        longint base;
        longint root;
        case ($urandom_range(0, 9))
            0, 1, 2: base = $urandom;
            3, 4:    base = $urandom_range(0, 400);
            5, 6:
            begin
                ring = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32768)
                                                   : $urandom_range(1, 200);
                base = (2 * ring - 1) * (2 * ring - 1) + $urandom_range(0, 3) * 2 * ring
                       + $urandom_range(0, 2) - 1;
            end
            7, 8:
            begin
                root = $urandom_range(0, 65535);
                base = root * root + $urandom_range(0, 2) - 1;
            end
            default: base = 64'hFFFF_0000 | $urandom_range(0, 65535);
        endcase
        if (base < 0)
            base = 0;
        if (base > 64'hFFFF_FFFF)
            base = 64'hFFFF_FFFF - $urandom_range(0, 3);
        return base[ssp_pkg::INDEX_BITS-1:0];
    endfunction

    initial
    begin
        rx_mode_t mode;
        int       left;
        mode = RX_OPEN;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_cell(m_axis_tdata);
            if (left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(8, 60);
            end
            left--;
            case (mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:  m_axis_tready <= (left % 5 == 0);
                default:    m_axis_tready <= 1'b0;
            endcase
        end
    end

    initial
    begin
        logic [ssp_pkg::INDEX_BITS-1:0] stimulus[$];
        int                             burst;
        int                             gap;
        rst_n <= 1'b0;
        sb = new();
        stimulus = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
                     32'd10, 32'd16, 32'd24, 32'd25, 32'd48, 32'd49, 32'd50,
                     32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0000,
                     32'hFFFE_0001, 32'hFFFF_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (550)
            stimulus.push_back(pick_index());

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stimulus.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && stimulus.size() > 0)
            begin
                send_index(stimulus.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0 || stimulus.size() == 0)
                s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (ssp_pkg::LATENCY + 8) @(posedge clk);
        sb.close_out();

        if (sb.errors == 0)
            $display("[square_spiral_index_to_point] OK");
        else
            $display("[square_spiral_index_to_point] ERROR");
        $finish;
    end
endmodule
